### hdl/efsp_pkg.sv
`default_nettype none
package efsp_pkg;

  // Entry geometry
  localparam int ENTRY_BYTES    = 32;
  localparam int NAME_BYTES     = 30;
  localparam int OFF_W          = $clog2(ENTRY_BYTES);
  localparam int NAME_RAM_DEPTH = 2 * ENTRY_BYTES;
  localparam int NAME_RAM_AW    = $clog2(NAME_RAM_DEPTH);
  localparam int CMD_DEPTH      = 4;
  localparam int CMD_AW         = $clog2(CMD_DEPTH);
  localparam int POS_W          = 13;
  localparam int SEEN_W         = 9;

  // Entry type codes
  localparam logic [7:0] TYPE_FILE   = 8'h85;
  localparam logic [7:0] TYPE_STREAM = 8'hC0;
  localparam logic [7:0] TYPE_NAME   = 8'hC1;

  // Byte offsets inside an entry
  localparam logic [OFF_W-1:0] OFF_TYPE      = 5'd0;
  localparam logic [OFF_W-1:0] OFF_BYTE1     = 5'd1;
  localparam logic [OFF_W-1:0] OFF_NAME      = 5'd2;
  localparam logic [OFF_W-1:0] OFF_ATTR_LO   = 5'd4;
  localparam logic [OFF_W-1:0] OFF_ATTR_HI   = 5'd5;
  localparam logic [OFF_W-1:0] OFF_CLUS_LO   = 5'd20;
  localparam logic [OFF_W-1:0] OFF_CLUS_HI   = 5'd23;
  localparam logic [OFF_W-1:0] OFF_LEN_LO    = 5'd24;
  localparam logic [OFF_W-1:0] OFF_LEN_HI    = 5'd30;
  localparam logic [OFF_W-1:0] OFF_LAST      = 5'd31;
  localparam logic [OFF_W-1:0] NAME_IDX_LAST = 5'd29;

  // Secondary index is held as index plus one: reset value 0 means minus one,
  // and it saturates at 256 plus one.
  localparam logic [SEEN_W-1:0] SEEN_FIRST = 9'd1;
  localparam logic [SEEN_W-1:0] SEEN_CAP   = 9'd257;

  // Result kinds
  localparam logic KIND_NAME    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CLS_OTHER  = 2'd0,
    CLS_FILE   = 2'd1,
    CLS_STREAM = 2'd2,
    CLS_NAME   = 2'd3
  } cls_e;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_NAME = 3'b010,
    ST_SUM  = 3'b100
  } back_state_e;

  // One request from the front to the back: an entry commit, a buffer end, or both
  typedef struct packed {
    logic        commit;
    logic        buffer_end;
    cls_e        cls;
    logic [7:0]  byte1;
    logic [15:0] attr;
    logic [31:0] cluster;
    logic [63:0] length;
    logic        bank;
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic bank;
  } rel_t;

  function automatic logic [SEEN_W-1:0] seen_adv(input logic [SEEN_W-1:0] s);
    seen_adv = (s < SEEN_CAP) ? SEEN_W'(s + 1'b1) : s;
  endfunction

endpackage
`default_nettype wire

### hdl/efsp_ram.sv
`default_nettype none
module efsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

### hdl/efsp_front.sv
`default_nettype none
module efsp_front (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_stall_o,
  input  wire logic [7:0]                          in_data_byte_i,
  input  wire logic                                in_buffer_end_i,
  input  wire logic                                cmd_full_i,
  output logic                                     cmd_push_o,
  output efsp_pkg::cmd_t                           cmd_o,
  input  wire efsp_pkg::rel_t                      rel_i,
  output logic                                     ram_we_o,
  output logic [efsp_pkg::NAME_RAM_AW-1:0]         ram_waddr_o,
  output logic [7:0]                               ram_wdata_o
);

  logic [efsp_pkg::OFF_W-1:0] offset_q, offset_d;
  logic                       wr_bank_q, wr_bank_d;
  logic [1:0]                 busy_q, busy_d;
  logic [7:0]                 type_q, byte1_q;
  logic [15:0]                attr_q;
  logic [31:0]                cluster_q;
  logic [55:0]                length_q;
  logic                       accept, commit;
  efsp_pkg::cls_e             cls;

  // Hold input while the queue is full or the bank being filled still drains
  assign in_stall_o = cmd_full_i || busy_q[wr_bank_q];
  assign accept     = in_valid_i && !in_stall_o;
  assign commit     = (offset_q == efsp_pkg::OFF_LAST);

  always_comb begin
    case (type_q)
      efsp_pkg::TYPE_FILE:   cls = efsp_pkg::CLS_FILE;
      efsp_pkg::TYPE_STREAM: cls = efsp_pkg::CLS_STREAM;
      efsp_pkg::TYPE_NAME:   cls = efsp_pkg::CLS_NAME;
      default:               cls = efsp_pkg::CLS_OTHER;
    endcase
  end

  assign ram_we_o    = accept;
  assign ram_waddr_o = {wr_bank_q, offset_q};
  assign ram_wdata_o = in_data_byte_i;

  assign cmd_push_o         = accept && (commit || in_buffer_end_i);
  assign cmd_o.commit       = commit;
  assign cmd_o.buffer_end   = in_buffer_end_i;
  assign cmd_o.cls          = cls;
  assign cmd_o.byte1        = byte1_q;
  assign cmd_o.attr         = attr_q;
  assign cmd_o.cluster      = cluster_q;
  assign cmd_o.length       = {in_data_byte_i, length_q};
  assign cmd_o.bank         = wr_bank_q;

  always_comb begin
    offset_d  = offset_q;
    wr_bank_d = wr_bank_q;
    busy_d    = busy_q;
    if (rel_i.valid) begin
      busy_d[rel_i.bank] = 1'b0;
    end
    if (accept) begin
      if (commit || in_buffer_end_i) begin
        offset_d = '0;
      end else begin
        offset_d = efsp_pkg::OFF_W'(offset_q + 1'b1);
      end
      if (commit && cls == efsp_pkg::CLS_NAME) begin
        busy_d[wr_bank_q] = 1'b1;
        wr_bank_d         = ~wr_bank_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q  <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      offset_q  <= offset_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

  // Capture header fields as their bytes go by
  always_ff @(posedge clk_i) begin
    if (accept) begin
      if (offset_q == efsp_pkg::OFF_TYPE) begin
        type_q <= in_data_byte_i;
      end
      if (offset_q == efsp_pkg::OFF_BYTE1) begin
        byte1_q <= in_data_byte_i;
      end
      if (offset_q == efsp_pkg::OFF_ATTR_LO) begin
        attr_q[7:0] <= in_data_byte_i;
      end
      if (offset_q == efsp_pkg::OFF_ATTR_HI) begin
        attr_q[15:8] <= in_data_byte_i;
      end
      if (offset_q >= efsp_pkg::OFF_CLUS_LO && offset_q <= efsp_pkg::OFF_CLUS_HI) begin
        cluster_q[{offset_q[1:0], 3'b000} +: 8] <= in_data_byte_i;
      end
      if (offset_q >= efsp_pkg::OFF_LEN_LO && offset_q <= efsp_pkg::OFF_LEN_HI) begin
        length_q[{offset_q[2:0], 3'b000} +: 8] <= in_data_byte_i;
      end
    end
  end

endmodule
`default_nettype wire

### hdl/efsp_cmd_fifo.sv
`default_nettype none
module efsp_cmd_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire efsp_pkg::cmd_t data_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output logic                valid_o,
  output efsp_pkg::cmd_t      data_o
);

  efsp_pkg::cmd_t            mem_q [efsp_pkg::CMD_DEPTH];
  logic [efsp_pkg::CMD_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [efsp_pkg::CMD_AW:0]   cnt_q;

  assign full_o  = (cnt_q == (efsp_pkg::CMD_AW + 1)'(efsp_pkg::CMD_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= efsp_pkg::CMD_AW'(wr_ptr_q + 1'b1);
      end
      if (pop_i) begin
        rd_ptr_q <= efsp_pkg::CMD_AW'(rd_ptr_q + 1'b1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= (efsp_pkg::CMD_AW + 1)'(cnt_q + 1'b1);
        2'b01:   cnt_q <= (efsp_pkg::CMD_AW + 1)'(cnt_q - 1'b1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule
`default_nettype wire

### hdl/efsp_back.sv
`default_nettype none
module efsp_back (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cmd_valid_i,
  input  wire efsp_pkg::cmd_t                      cmd_i,
  output logic                                     cmd_pop_o,
  output efsp_pkg::rel_t                           rel_o,
  output logic                                     ram_re_o,
  output logic [efsp_pkg::NAME_RAM_AW-1:0]         ram_raddr_o,
  input  wire logic [7:0]                          ram_rdata_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_stall_i,
  output logic                                     out_kind_o,
  output logic [7:0]                               out_name_byte_o,
  output logic [efsp_pkg::POS_W-1:0]               out_name_position_o,
  output logic                                     out_complete_o,
  output logic [7:0]                               out_secondary_count_o,
  output logic [15:0]                              out_file_attributes_o,
  output logic [31:0]                              out_first_cluster_o,
  output logic [7:0]                               out_secondary_flags_o,
  output logic [63:0]                              out_data_length_o,
  output logic                                     out_last_o
);

  efsp_pkg::back_state_e st_q, st_d;
  logic [efsp_pkg::OFF_W-1:0]  idx_q, idx_d;
  logic                        nbank_q, nbank_d, nend_q, nend_d, scomp_q, scomp_d;
  logic [7:0]                  count_q, count_d, flags_q, flags_d;
  logic [15:0]                 attr_q, attr_d;
  logic [31:0]                 cluster_q, cluster_d;
  logic [63:0]                 length_q, length_d;
  logic [efsp_pkg::POS_W-1:0]  cursor_q, cursor_d;
  logic [efsp_pkg::SEEN_W-1:0] seen_q, seen_d;

  logic [7:0]                  u_count, u_flags;
  logic [15:0]                 u_attr;
  logic [31:0]                 u_cluster;
  logic [63:0]                 u_length;
  logic [efsp_pkg::SEEN_W-1:0] u_seen;
  logic                        done, restart, pop_raw, rel_raw;

  logic                        iss_valid, iss_kind, iss_complete, iss_last;
  logic [efsp_pkg::POS_W-1:0]  iss_pos;
  logic [7:0]                  iss_count, iss_flags;
  logic [15:0]                 iss_attr;
  logic [31:0]                 iss_cluster;
  logic [63:0]                 iss_length;

  logic                        p1_valid_q, p1_kind_q, p1_complete_q, p1_last_q;
  logic [efsp_pkg::POS_W-1:0]  p1_pos_q;
  logic [7:0]                  p1_count_q, p1_flags_q;
  logic [15:0]                 p1_attr_q;
  logic [31:0]                 p1_cluster_q;
  logic [63:0]                 p1_length_q;

  logic                        out_valid_q, advance;

  // The whole read pipe moves together; the RAM read register moves with it
  assign advance     = !out_valid_q || !out_stall_i;
  assign ram_re_o    = advance;
  assign ram_raddr_o = {nbank_q, efsp_pkg::OFF_W'(idx_q + efsp_pkg::OFF_NAME)};
  assign cmd_pop_o   = pop_raw && advance;
  assign rel_o.valid = rel_raw && advance;
  assign rel_o.bank  = nbank_q;
  assign out_valid_o = out_valid_q;

  always_comb begin
    u_count   = count_q;
    u_flags   = flags_q;
    u_attr    = attr_q;
    u_cluster = cluster_q;
    u_length  = length_q;
    u_seen    = seen_q;
    st_d      = st_q;
    idx_d     = idx_q;
    nbank_d   = nbank_q;
    nend_d    = nend_q;
    scomp_d   = scomp_q;
    count_d   = count_q;
    flags_d   = flags_q;
    attr_d    = attr_q;
    cluster_d = cluster_q;
    length_d  = length_q;
    cursor_d  = cursor_q;
    seen_d    = seen_q;
    done      = 1'b0;
    restart   = 1'b0;
    pop_raw   = 1'b0;
    rel_raw   = 1'b0;
    iss_valid    = 1'b0;
    iss_kind     = efsp_pkg::KIND_NAME;
    iss_pos      = cursor_q;
    iss_complete = 1'b0;
    iss_last     = 1'b0;
    iss_count    = '0;
    iss_flags    = '0;
    iss_attr     = '0;
    iss_cluster  = '0;
    iss_length   = '0;
    case (st_q)
      efsp_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          pop_raw = 1'b1;
          if (cmd_i.commit) begin
            case (cmd_i.cls)
              efsp_pkg::CLS_FILE: begin
                u_seen  = efsp_pkg::SEEN_FIRST;
                u_count = cmd_i.byte1;
                u_attr  = cmd_i.attr;
              end
              efsp_pkg::CLS_STREAM: begin
                u_flags   = cmd_i.byte1;
                u_cluster = cmd_i.cluster;
                u_length  = cmd_i.length;
                u_seen    = efsp_pkg::seen_adv(seen_q);
              end
              default: begin
              end
            endcase
          end
          done = cmd_i.commit && (cmd_i.cls != efsp_pkg::CLS_NAME) &&
                 (u_seen > {1'b0, u_count});
          if (cmd_i.commit && cmd_i.cls == efsp_pkg::CLS_NAME) begin
            st_d    = efsp_pkg::ST_NAME;
            idx_d   = '0;
            nbank_d = cmd_i.bank;
            nend_d  = cmd_i.buffer_end;
          end else if (done || cmd_i.buffer_end) begin
            iss_valid    = 1'b1;
            iss_kind     = efsp_pkg::KIND_SUMMARY;
            iss_complete = done;
            iss_last     = 1'b1;
            iss_count    = u_count;
            iss_flags    = u_flags;
            iss_attr     = u_attr;
            iss_cluster  = u_cluster;
            iss_length   = u_length;
            restart      = 1'b1;
          end else begin
            count_d   = u_count;
            flags_d   = u_flags;
            attr_d    = u_attr;
            cluster_d = u_cluster;
            length_d  = u_length;
            seen_d    = u_seen;
          end
        end
      end
      efsp_pkg::ST_NAME: begin
        iss_valid = 1'b1;
        cursor_d  = efsp_pkg::POS_W'(cursor_q + 1'b1);
        idx_d     = efsp_pkg::OFF_W'(idx_q + 1'b1);
        if (idx_q == efsp_pkg::NAME_IDX_LAST) begin
          u_seen   = efsp_pkg::seen_adv(seen_q);
          seen_d   = u_seen;
          done     = (u_seen > {1'b0, count_q});
          rel_raw  = 1'b1;
          iss_last = !(done || nend_q);
          if (done || nend_q) begin
            st_d    = efsp_pkg::ST_SUM;
            scomp_d = done;
          end else begin
            st_d = efsp_pkg::ST_IDLE;
          end
        end
      end
      efsp_pkg::ST_SUM: begin
        iss_valid    = 1'b1;
        iss_kind     = efsp_pkg::KIND_SUMMARY;
        iss_complete = scomp_q;
        iss_last     = 1'b1;
        iss_count    = count_q;
        iss_flags    = flags_q;
        iss_attr     = attr_q;
        iss_cluster  = cluster_q;
        iss_length   = length_q;
        restart      = 1'b1;
        st_d         = efsp_pkg::ST_IDLE;
      end
      default: begin
        st_d = efsp_pkg::ST_IDLE;
      end
    endcase
    // Drop all set state once its summary goes out
    if (restart) begin
      count_d   = '0;
      flags_d   = '0;
      attr_d    = '0;
      cluster_d = '0;
      length_d  = '0;
      cursor_d  = '0;
      seen_d    = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= efsp_pkg::ST_IDLE;
      idx_q       <= '0;
      nbank_q     <= 1'b0;
      nend_q      <= 1'b0;
      scomp_q     <= 1'b0;
      count_q     <= '0;
      flags_q     <= '0;
      attr_q      <= '0;
      cluster_q   <= '0;
      length_q    <= '0;
      cursor_q    <= '0;
      seen_q      <= '0;
      p1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      st_q        <= st_d;
      idx_q       <= idx_d;
      nbank_q     <= nbank_d;
      nend_q      <= nend_d;
      scomp_q     <= scomp_d;
      count_q     <= count_d;
      flags_q     <= flags_d;
      attr_q      <= attr_d;
      cluster_q   <= cluster_d;
      length_q    <= length_d;
      cursor_q    <= cursor_d;
      seen_q      <= seen_d;
      p1_valid_q  <= iss_valid;
      out_valid_q <= p1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      p1_kind_q             <= iss_kind;
      p1_pos_q              <= iss_pos;
      p1_complete_q         <= iss_complete;
      p1_last_q             <= iss_last;
      p1_count_q            <= iss_count;
      p1_flags_q            <= iss_flags;
      p1_attr_q             <= iss_attr;
      p1_cluster_q          <= iss_cluster;
      p1_length_q           <= iss_length;
      out_kind_o            <= p1_kind_q;
      out_name_byte_o       <= (p1_kind_q == efsp_pkg::KIND_NAME) ? ram_rdata_i : 8'd0;
      out_name_position_o   <= p1_pos_q;
      out_complete_o        <= p1_complete_q;
      out_last_o            <= p1_last_q;
      out_secondary_count_o <= p1_count_q;
      out_secondary_flags_o <= p1_flags_q;
      out_file_attributes_o <= p1_attr_q;
      out_first_cluster_o   <= p1_cluster_q;
      out_data_length_o     <= p1_length_q;
    end
  end

endmodule
`default_nettype wire

### hdl/exfat_entry_set_parser_top.sv
// exFAT directory entry set parser. Takes one directory byte per cycle and
// groups bytes into 32-byte entries; an entry acts only on its 32nd byte.
// A file entry (0x85) opens a set, a stream extension (0xC0) loads flags,
// first cluster and data length, and each name entry (0xC1) yields its 30
// name bytes, one result per cycle, with running positions. When the
// secondary index reaches the count, or a byte flagged as buffer end
// arrives, one summary result closes the set. A byte is taken every cycle
// while the four-entry request queue has room and the name buffer being
// filled is free; the back end drains a name entry by taking its request and
// then issuing its 30 name bytes, plus a summary, reading a two-bank
// name RAM, so name bytes are double buffered against the next entry.
// Results leave at most one per cycle, registered in p1 and then the output
// register after issue, and an output stall holds the whole back end.
`default_nettype none
module exfat_entry_set_parser_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [7:0]  in_data_byte_i,
  input  wire logic        in_buffer_end_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             out_kind_o,
  output logic [7:0]       out_name_byte_o,
  output logic [12:0]      out_name_position_o,
  output logic             out_complete_o,
  output logic [7:0]       out_secondary_count_o,
  output logic [15:0]      out_file_attributes_o,
  output logic [31:0]      out_first_cluster_o,
  output logic [7:0]       out_secondary_flags_o,
  output logic [63:0]      out_data_length_o,
  output logic             out_last_o
);

  // Front to queue
  logic           cmd_push, cmd_full;
  efsp_pkg::cmd_t cmd_in;
  // Queue to back
  logic           cmd_pop, cmd_valid;
  efsp_pkg::cmd_t cmd_out;
  // Name bank release from back to front
  efsp_pkg::rel_t rel;
  // Name RAM ports
  logic                              ram_we, ram_re;
  logic [efsp_pkg::NAME_RAM_AW-1:0]  ram_waddr, ram_raddr;
  logic [7:0]                        ram_wdata, ram_rdata;

  // Front: track the byte offset, capture header fields, write name bytes
  efsp_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .in_data_byte_i  (in_data_byte_i),
    .in_buffer_end_i (in_buffer_end_i),
    .cmd_full_i      (cmd_full),
    .cmd_push_o      (cmd_push),
    .cmd_o           (cmd_in),
    .rel_i           (rel),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata)
  );

  // Two banks of one entry each; the front fills one while the back reads the other
  efsp_ram #(
    .WIDTH (8),
    .DEPTH (efsp_pkg::NAME_RAM_DEPTH)
  ) u_name_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Request queue decouples byte intake from result draining
  efsp_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .data_i  (cmd_in),
    .full_o  (cmd_full),
    .pop_i   (cmd_pop),
    .valid_o (cmd_valid),
    .data_o  (cmd_out)
  );

  // Back: hold the set state, stream name bytes, emit summaries
  efsp_back u_back (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_valid_i           (cmd_valid),
    .cmd_i                 (cmd_out),
    .cmd_pop_o             (cmd_pop),
    .rel_o                 (rel),
    .ram_re_o              (ram_re),
    .ram_raddr_o           (ram_raddr),
    .ram_rdata_i           (ram_rdata),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_kind_o            (out_kind_o),
    .out_name_byte_o       (out_name_byte_o),
    .out_name_position_o   (out_name_position_o),
    .out_complete_o        (out_complete_o),
    .out_secondary_count_o (out_secondary_count_o),
    .out_file_attributes_o (out_file_attributes_o),
    .out_first_cluster_o   (out_first_cluster_o),
    .out_secondary_flags_o (out_secondary_flags_o),
    .out_data_length_o     (out_data_length_o),
    .out_last_o            (out_last_o)
  );

  // The front never pushes a request into a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(cmd_push && cmd_full))
    else $error("request pushed into full queue");

  // The back never pops an empty queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) cmd_pop |-> cmd_valid)
    else $error("request popped from empty queue");

  // A summary always closes the results of its byte
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_kind_o == efsp_pkg::KIND_SUMMARY) |-> out_last_o)
    else $error("summary result without last");

  // A name byte result never claims completion
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && out_kind_o == efsp_pkg::KIND_NAME) |-> !out_complete_o)
    else $error("name byte result marked complete");

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
module tb_top;

  localparam int HALF_PERIOD = 10;
  localparam int RESET_CYCLES = 4;
  localparam int IDLE_LIMIT = 1000;
  localparam int REPORT_MAX = 10;
  localparam int DRAIN_TAIL = 16;

  // One directory entry as sent, byte i at index i
  typedef logic [efsp_pkg::ENTRY_BYTES-1:0][7:0] entry_t;

  // One result of the parser, name byte or set summary
  typedef struct {
    logic        kind;
    logic [7:0]  name_byte;
    logic [12:0] position;
    logic        complete;
    logic [7:0]  count;
    logic [15:0] attr;
    logic [31:0] cluster;
    logic [7:0]  flags;
    logic [63:0] length;
    logic        last;
  } dir_result_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_RANDOM,
    STALL_RUNS
  } stall_mode_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [7:0]  in_data_byte_i = 8'h00;
  logic        in_buffer_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        out_kind_o;
  logic [7:0]  out_name_byte_o;
  logic [12:0] out_name_position_o;
  logic        out_complete_o;
  logic [7:0]  out_secondary_count_o;
  logic [15:0] out_file_attributes_o;
  logic [31:0] out_first_cluster_o;
  logic [7:0]  out_secondary_flags_o;
  logic [63:0] out_data_length_o;
  logic        out_last_o;

  exfat_entry_set_parser_top DUT (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .in_valid_i            (in_valid_i),
    .in_stall_o            (in_stall_o),
    .in_data_byte_i        (in_data_byte_i),
    .in_buffer_end_i       (in_buffer_end_i),
    .out_valid_o           (out_valid_o),
    .out_stall_i           (out_stall_i),
    .out_kind_o            (out_kind_o),
    .out_name_byte_o       (out_name_byte_o),
    .out_name_position_o   (out_name_position_o),
    .out_complete_o        (out_complete_o),
    .out_secondary_count_o (out_secondary_count_o),
    .out_file_attributes_o (out_file_attributes_o),
    .out_first_cluster_o   (out_first_cluster_o),
    .out_secondary_flags_o (out_secondary_flags_o),
    .out_data_length_o     (out_data_length_o),
    .out_last_o            (out_last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #HALF_PERIOD clk_i = ~clk_i;
  end

  // Parser state as predicted from the accepted byte requests
  logic [4:0]  pr_offset = '0;
  logic [7:0]  pr_stage [efsp_pkg::ENTRY_BYTES];
  logic [7:0]  pr_count = '0;
  int          pr_seen = -1;
  logic [15:0] pr_attr = '0;
  logic [31:0] pr_cluster = '0;
  logic [7:0]  pr_flags = '0;
  logic [63:0] pr_length = '0;
  logic [12:0] pr_cursor = '0;

  dir_result_t expected_results [$];
  int          mismatch_cnt = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;

  initial begin
    foreach (pr_stage[i]) pr_stage[i] = 8'h00;
  end

  task automatic restart_set();
    pr_count   = '0;
    pr_seen    = -1;
    pr_attr    = '0;
    pr_cluster = '0;
    pr_flags   = '0;
    pr_length  = '0;
    pr_cursor  = '0;
  endtask

  task automatic bump_index();
    if (pr_seen < 256) pr_seen++;
  endtask

  // Advance the predicted parser by one byte and queue what it emits
  task automatic parse_byte(input logic [7:0] b, input logic buf_end);
    dir_result_t r;
    dir_result_t batch [$];
    bit          done;
    logic [7:0]  kind_code;
    done = 1'b0;
    pr_stage[pr_offset] = b;
    if (pr_offset == 5'(efsp_pkg::ENTRY_BYTES - 1)) begin
      pr_offset = '0;
      kind_code = pr_stage[0];
      if (kind_code == efsp_pkg::TYPE_FILE) begin
        pr_seen  = 0;
        pr_count = pr_stage[1];
        pr_attr  = {pr_stage[5], pr_stage[4]};
      end else if (kind_code == efsp_pkg::TYPE_STREAM) begin
        pr_flags   = pr_stage[1];
        pr_cluster = {pr_stage[23], pr_stage[22], pr_stage[21], pr_stage[20]};
        for (int i = 0; i < 8; i++) pr_length[8*i +: 8] = pr_stage[24 + i];
        bump_index();
      end else if (kind_code == efsp_pkg::TYPE_NAME) begin
        for (int i = 0; i < efsp_pkg::NAME_BYTES; i++) begin
          r = '{default: '0};
          r.kind      = efsp_pkg::KIND_NAME;
          r.name_byte = pr_stage[2 + i];
          r.position  = pr_cursor;
          pr_cursor   = pr_cursor + 13'd1;
          batch.push_back(r);
        end
        bump_index();
      end
      done = (pr_seen >= int'(pr_count));
    end else begin
      pr_offset = pr_offset + 5'd1;
    end

    if (done || buf_end) begin
      r = '{default: '0};
      r.kind     = efsp_pkg::KIND_SUMMARY;
      r.position = pr_cursor;
      r.complete = done;
      r.count    = pr_count;
      r.attr     = pr_attr;
      r.cluster  = pr_cluster;
      r.flags    = pr_flags;
      r.length   = pr_length;
      batch.push_back(r);
      restart_set();
      if (buf_end) pr_offset = '0;
    end

    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) expected_results.push_back(batch[i]);
  endtask

  // Send one byte request; called just after a rising edge, returns just after one
  task automatic send_byte(input logic [7:0] b, input logic buf_end);
    in_valid_i      <= 1'b1;
    in_data_byte_i  <= b;
    in_buffer_end_i <= buf_end;
    @(negedge clk_i);
    while (in_stall_o) begin
      @(posedge clk_i);
      @(negedge clk_i);
    end
    parse_byte(b, buf_end);
    @(posedge clk_i);
    // bursts of random length, random gaps between them
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(0, 40);
    end
  endtask

  // Send an entry; a buffer end at end_at drops the rest of it
  task automatic send_entry(input entry_t e, input int end_at);
    for (int i = 0; i < efsp_pkg::ENTRY_BYTES; i++) begin
      send_byte(e[i], i == end_at);
      if (i == end_at) return;
    end
  endtask

  // Hold the sender until every expected result is out, then let the pipe settle
  task automatic wait_results_drained();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_TAIL) @(posedge clk_i);
  endtask

  function automatic entry_t random_entry(input logic [7:0] kind_code);
    entry_t e;
    for (int i = 0; i < efsp_pkg::ENTRY_BYTES; i++) e[i] = 8'($urandom);
    e[0] = kind_code;
    return e;
  endfunction

  function automatic entry_t filled_entry(input logic [7:0] kind_code, input logic [7:0] fill);
    entry_t e;
    for (int i = 0; i < efsp_pkg::ENTRY_BYTES; i++) e[i] = fill;
    e[0] = kind_code;
    return e;
  endfunction

  function automatic entry_t file_entry(input logic [7:0] count, input logic [15:0] attr);
    entry_t e;
    e = random_entry(efsp_pkg::TYPE_FILE);
    e[1] = count;
    e[4] = attr[7:0];
    e[5] = attr[15:8];
    return e;
  endfunction

  function automatic entry_t stream_entry(input logic [7:0] flags, input logic [31:0] cluster,
                                          input logic [63:0] length);
    entry_t e;
    e = random_entry(efsp_pkg::TYPE_STREAM);
    e[1] = flags;
    for (int i = 0; i < 4; i++) e[20 + i] = cluster[8*i +: 8];
    for (int i = 0; i < 8; i++) e[24 + i] = length[8*i +: 8];
    return e;
  endfunction

  // A full set with the field extremes; the buffer end on its completing byte
  // yields a single summary
  task automatic test_full_sets();
    send_entry(file_entry(8'd1, 16'hFFFF), -1);
    send_entry(stream_entry(8'hFF, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF),
               efsp_pkg::ENTRY_BYTES - 1);
  endtask

  // A name entry with no file entry streams its bytes and closes at once
  task automatic test_orphan_secondaries();
    send_entry(filled_entry(efsp_pkg::TYPE_NAME, 8'hFF), -1);
  endtask

  // Buffer end in the middle of an entry drops it and closes the set unfinished
  task automatic test_buffer_end();
    send_entry(random_entry(8'($urandom)), $urandom_range(0, 3));
  endtask

  // Receiver stall pattern: phases of no stall, random stall, and long stall runs
  stall_mode_e stall_mode = STALL_NONE;
  int          phase_left = 0;
  int          run_left = 0;

  always @(posedge clk_i) begin
    if (phase_left == 0) begin
      stall_mode <= stall_mode_e'($urandom_range(0, 2));
      phase_left <= $urandom_range(20, 150);
    end else begin
      phase_left <= phase_left - 1;
    end
    case (stall_mode)
      STALL_NONE: begin
        out_stall_i <= 1'b0;
      end
      STALL_RANDOM: begin
        out_stall_i <= ($urandom_range(0, 2) == 0);
      end
      default: begin
        if (run_left == 0) begin
          out_stall_i <= ~out_stall_i;
          run_left    <= $urandom_range(1, 12);
        end else begin
          run_left <= run_left - 1;
        end
      end
    endcase
  end

  task automatic check_field(input string what, input logic [63:0] want, input logic [63:0] got);
    if (got !== want) begin
      if (mismatch_cnt < REPORT_MAX)
        $display("mismatch in %0s: expected %0h, got %0h", what, want, got);
      mismatch_cnt++;
    end
  endtask

  // Compare each accepted result with the oldest expectation; sample mid-cycle
  always @(negedge clk_i) begin
    dir_result_t r;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i == 1'b0) begin
      if (expected_results.size() == 0) begin
        if (mismatch_cnt < REPORT_MAX)
          $display("result with nothing expected: kind %0h position %0h",
                   out_kind_o, out_name_position_o);
        mismatch_cnt++;
      end else begin
        r = expected_results.pop_front();
        check_field("kind", 64'(r.kind), 64'(out_kind_o));
        check_field("name_byte", 64'(r.name_byte), 64'(out_name_byte_o));
        check_field("name_position", 64'(r.position), 64'(out_name_position_o));
        check_field("complete", 64'(r.complete), 64'(out_complete_o));
        check_field("secondary_count", 64'(r.count), 64'(out_secondary_count_o));
        check_field("file_attributes", 64'(r.attr), 64'(out_file_attributes_o));
        check_field("first_cluster", 64'(r.cluster), 64'(out_first_cluster_o));
        check_field("secondary_flags", 64'(r.flags), 64'(out_secondary_flags_o));
        check_field("data_length", r.length, out_data_length_o);
        check_field("last", 64'(r.last), 64'(out_last_o));
      end
    end
  end

  // Watchdog: end the run when neither channel moves a request for too long
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT) begin
          $display("exfat_entry_set_parser_top verification failed");
          $finish;
        end
      end
    end
  end

  initial begin
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_full_sets();
    wait_results_drained();
    test_orphan_secondaries();
    test_buffer_end();
    wait_results_drained();

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("exfat_entry_set_parser_top verification clean");
    end else begin
      $display("exfat_entry_set_parser_top verification failed");
    end
    $finish;
  end

endmodule
